@@ hw/rtl/complex_arithmetic_unit_macros.svh @@
// assertion macros used by the rtl
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CAU_ASSERT_IMPL(lbl, ante, cons, msg)
`define CAU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/cau_pkg.sv @@
package cau_pkg;

  // fixed point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int WIDE_W    = 64;
  localparam int Q_W       = 34;
  // restoring divider steps and root steps, one per stage
  localparam int NDIV      = WIDE_W + FRAC_BITS;
  localparam int NSQRT     = 32;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MAG = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [Q_W-1:0] Q_CAP = Q_W'(64'd1 << 33);

  typedef struct packed {
    logic [WIDE_W-1:0] r;
    logic [WIDE_W-1:0] m;
    logic [Q_W-1:0]    q;
  } div_t;

  typedef struct packed {
    logic [2:0]        op;
    logic [DATA_W-1:0] er;
    logic [DATA_W-1:0] ei;
    logic [1:0]        est;
    logic              dz;
    logic              nr;
    logic              ni;
    logic [WIDE_W-1:0] dd;
    div_t              dr;
    div_t              di;
    logic [WIDE_W-1:0] sq;
    logic [WIDE_W-1:0] rt;
  } it_t;

  typedef struct packed {
    logic [DATA_W-1:0] re;
    logic [DATA_W-1:0] im;
    logic [1:0]        st;
  } res_t;

  // one restoring division step, quotient held once it reaches the cap
  function automatic div_t div_step(input div_t x, input logic [WIDE_W-1:0] d);
    logic [WIDE_W:0] t;
    logic            qb;
    div_t            y;
    t  = {x.r, x.m[WIDE_W-1]};
    qb = 1'b0;
    if (t >= {1'b0, d}) begin
      t  = t - {1'b0, d};
      qb = 1'b1;
    end
    y.r = t[WIDE_W-1:0];
    y.m = {x.m[WIDE_W-2:0], 1'b0};
    y.q = (x.q < Q_CAP) ? {x.q[Q_W-2:0], qb} : x.q;
    return y;
  endfunction

  // clamp sign and magnitude to 32 bits, msb of result flags saturation
  function automatic logic [DATA_W:0] sat_mag(input logic neg, input logic [WIDE_W-1:0] mag);
    logic [WIDE_W-1:0] n;
    n = -mag;
    if (!neg) begin
      if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, mag[DATA_W-1:0]};
    end
    if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
    return {1'b0, n[DATA_W-1:0]};
  endfunction

endpackage

@@ hw/rtl/complex_arithmetic_unit.sv @@
// Complex arithmetic unit: add, subtract, multiply, divide or magnitude of two complex
// operands in signed fixed point with cau_pkg::FRAC_BITS fraction bits (Q16.16). Fully
// pipelined: one beat accepted per cycle while in_ready_o is high. The pipeline depth is
// set by the restoring divider that spends one stage per quotient bit. The square root
// runs in the first 32 of those stages. An output register plus one skid stage let input
// continue while one result waits; in_ready_o drops only while the skid stage is full.
`include "complex_arithmetic_unit_macros.svh"
module complex_arithmetic_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          operation_i,
  input  logic signed [31:0]  first_real_i,
  input  logic signed [31:0]  first_imag_i,
  input  logic signed [31:0]  second_real_i,
  input  logic signed [31:0]  second_imag_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  result_real_o,
  output logic signed [31:0]  result_imag_o,
  output logic [1:0]          status_o
);

  localparam int N = cau_pkg::NDIV;

  logic en;

  // one divider step for both quotients and, in the first NSQRT stages, one root step, bit weight fixed by stage index
  function automatic cau_pkg::it_t it_step(input cau_pkg::it_t x, input int k);
    cau_pkg::it_t            y;
    logic [cau_pkg::WIDE_W-1:0] b;
    logic [cau_pkg::WIDE_W-1:0] t;
    y    = x;
    y.dr = cau_pkg::div_step(x.dr, x.dd);
    y.di = cau_pkg::div_step(x.di, x.dd);
    if (k < cau_pkg::NSQRT) begin
      b = 64'd1 << (62 - 2 * k);
      t = x.rt + b;
      if (x.sq >= t) begin
        y.sq = x.sq - t;
        y.rt = (x.rt >> 1) + b;
      end else begin
        y.rt = x.rt >> 1;
      end
    end
    return y;
  endfunction

  // stage a: operand registers
  logic              va_q;
  logic [2:0]        opa_q;
  logic signed [31:0] a_q, b_q, c_q, d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opa_q <= operation_i;
      a_q   <= first_real_i;
      b_q   <= first_imag_i;
      c_q   <= second_real_i;
      d_q   <= second_imag_i;
    end
  end

  // stage b: products and add/sub results
  logic              vb_q;
  logic [2:0]        opb_q;
  logic [31:0]       erb_q, eib_q;
  logic [1:0]        estb_q;
  logic signed [63:0] pac_q, pbd_q, pad_q, pbc_q, pcc_q, pdd_q;
  logic signed [31:0] mx0, mx1;
  logic signed [32:0] sr, si;
  logic [31:0]       er_d, ei_d;
  logic              ovr, ovi;

  always_comb begin
    mx0 = (opa_q == cau_pkg::OP_MAG) ? a_q : c_q;
    mx1 = (opa_q == cau_pkg::OP_MAG) ? b_q : d_q;
    if (opa_q == cau_pkg::OP_ADD) begin
      sr = 33'(a_q) + 33'(c_q);
      si = 33'(b_q) + 33'(d_q);
    end else begin
      sr = 33'(a_q) - 33'(c_q);
      si = 33'(b_q) - 33'(d_q);
    end
    ovr  = sr[32] != sr[31];
    ovi  = si[32] != si[31];
    er_d = ovr ? (sr[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sr[31:0];
    ei_d = ovi ? (si[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : si[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opb_q  <= opa_q;
      pac_q  <= a_q * mx0;
      pbd_q  <= b_q * mx1;
      pad_q  <= a_q * d_q;
      pbc_q  <= b_q * c_q;
      pcc_q  <= c_q * c_q;
      pdd_q  <= d_q * d_q;
      if (opa_q == cau_pkg::OP_ADD || opa_q == cau_pkg::OP_SUB) begin
        erb_q  <= er_d;
        eib_q  <= ei_d;
        estb_q <= (ovr || ovi) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end else begin
        erb_q  <= '0;
        eib_q  <= '0;
        estb_q <= cau_pkg::ST_OK;
      end
    end
  end

  // stage c: wide sums and denominator
  logic              vc_q;
  logic [2:0]        opc_q;
  logic [31:0]       erc_q, eic_q;
  logic [1:0]        estc_q;
  logic signed [65:0] sre_q, sim_q;
  logic [63:0]       den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      opc_q  <= opb_q;
      erc_q  <= erb_q;
      eic_q  <= eib_q;
      estc_q <= estb_q;
      den_q  <= $unsigned(pcc_q) + $unsigned(pdd_q);
      if (opb_q == cau_pkg::OP_MUL) begin
        sre_q <= 66'(pac_q) - 66'(pbd_q);
        sim_q <= 66'(pad_q) + 66'(pbc_q);
      end else begin
        sre_q <= 66'(pac_q) + 66'(pbd_q);
        sim_q <= 66'(pbc_q) - 66'(pad_q);
      end
    end
  end

  // stage d: sign and magnitude, product results, iteration setup
  cau_pkg::it_t it_q [0:N];
  logic         vi_q [0:N];
  cau_pkg::it_t it0_d;
  logic         nr_d, ni_d;
  logic [65:0]  ar, ai;
  logic [32:0]  mr_s, mi_s;

  always_comb begin
    nr_d = sre_q[65];
    ni_d = sim_q[65];
    ar   = nr_d ? -sre_q : sre_q;
    ai   = ni_d ? -sim_q : sim_q;
    mr_s = cau_pkg::sat_mag(nr_d, ar[63:0] >> cau_pkg::FRAC_BITS);
    mi_s = cau_pkg::sat_mag(ni_d, ai[63:0] >> cau_pkg::FRAC_BITS);
    it0_d      = '0;
    it0_d.op   = opc_q;
    it0_d.er   = erc_q;
    it0_d.ei   = eic_q;
    it0_d.est  = estc_q;
    it0_d.dz   = den_q == '0;
    it0_d.nr   = nr_d;
    it0_d.ni   = ni_d;
    it0_d.dd   = den_q;
    it0_d.dr.m = ar[63:0];
    it0_d.di.m = ai[63:0];
    it0_d.sq   = ar[63:0];
    if (opc_q == cau_pkg::OP_MUL) begin
      it0_d.er  = mr_s[31:0];
      it0_d.ei  = mi_s[31:0];
      it0_d.est = (mr_s[32] || mi_s[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vi_q[0] <= 1'b0;
    end else if (en) begin
      vi_q[0] <= vc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      it_q[0] <= it0_d;
    end
  end

  // divider and root stages
  for (genvar k = 0; k < N; k++) begin : g_it
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vi_q[k+1] <= 1'b0;
      end else if (en) begin
        vi_q[k+1] <= vi_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        it_q[k+1] <= it_step(it_q[k], k);
      end
    end
  end

  // final selection and saturation
  cau_pkg::res_t fin;
  logic [32:0]   qr_s, qi_s, rt_s;

  always_comb begin
    qr_s = cau_pkg::sat_mag(it_q[N].nr, 64'(it_q[N].dr.q));
    qi_s = cau_pkg::sat_mag(it_q[N].ni, 64'(it_q[N].di.q));
    rt_s = cau_pkg::sat_mag(1'b0, it_q[N].rt);
    fin.re = it_q[N].er;
    fin.im = it_q[N].ei;
    fin.st = it_q[N].est;
    case (it_q[N].op)
      cau_pkg::OP_DIV: begin
        if (it_q[N].dz) begin
          fin.re = '0;
          fin.im = '0;
          fin.st = cau_pkg::ST_DIVZ;
        end else begin
          fin.re = qr_s[31:0];
          fin.im = qi_s[31:0];
          fin.st = (qr_s[32] || qi_s[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
      end
      cau_pkg::OP_MAG: begin
        fin.re = rt_s[31:0];
        fin.im = '0;
        fin.st = rt_s[32] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
      end
      default: begin
      end
    endcase
  end

  // output register and skid stage
  logic          out_valid_q, skid_valid_q;
  cau_pkg::res_t out_q, skid_q;
  logic          emit;

  assign en   = !skid_valid_q;
  assign emit = en && vi_q[N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q  <= skid_valid_q || emit;
      skid_valid_q <= 1'b0;
    end else if (emit) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_valid_q ? skid_q : fin;
    end else if (emit) begin
      skid_q <= fin;
    end
  end

  assign in_ready_o    = en;
  assign out_valid_o   = out_valid_q;
  assign result_real_o = out_q.re;
  assign result_imag_o = out_q.im;
  assign status_o      = out_q.st;

  // checks
  `CAU_ASSERT_IMPL(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
  `CAU_ASSERT_IMPL(a_skid_blocks_in, skid_valid_q, !in_ready_o, "input open with skid full")
  `CAU_ASSERT_NEXT(a_skid_fill, out_valid_q && !out_ready_i && !skid_valid_q && vi_q[N], skid_valid_q, "stalled beat not kept in skid")
  `CAU_ASSERT_IMPL(a_divz_zero, out_valid_o && status_o == cau_pkg::ST_DIVZ, result_real_o == '0 && result_imag_o == '0, "division by zero gives nonzero result")

endmodule
